>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros for the blitter checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk and disabled in reset
`define SBTB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbtb check failed");

// next-cycle implication, clocked on clk and disabled in reset
`define SBTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbtb check failed");

`endif

>>> design/sbtb_pkg.sv
// ----------------------------------------------------------------------------
// sbtb_pkg
// widths, codes, types and small tables of the bitmap text blitter
// ----------------------------------------------------------------------------
package sbtb_pkg;

  // word field widths
  localparam int CMD_W    = 2;
  localparam int ROW_W    = 5;
  localparam int BCOL_W   = 8;
  localparam int PIX_W    = 8;
  localparam int SQX_W    = 8;
  localparam int SQY_W    = 7;
  localparam int SIDE_W   = 3;
  localparam int COLR_W   = 16;

  // configuration register widths
  localparam int SCL_W      = 3;
  localparam int TW_W       = 11;
  localparam int SPD_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // internal widths
  localparam int POS_W  = 16;
  localparam int REM_W  = 2;
  localparam int TWS_W  = 14;
  localparam int CC_W   = 11;
  localparam int X_W    = 17;
  localparam int Y_W    = 9;
  localparam int HGT_W  = 8;
  localparam int ACC_W  = 4;
  localparam int SPT_W  = 3;

  // parameter defaults
  localparam int DEF_PANEL_WIDTH    = 64;
  localparam int DEF_PANEL_HEIGHT   = 32;
  localparam int DEF_MAX_TEXT_WIDTH = 2048;
  localparam int DEF_SCROLL_ROWS    = 16;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOUR = 3'd4;

  // configuration seen by the datapath units
  typedef struct packed {
    logic              scroll_mode;
    logic [SCL_W-1:0]  scale_eff;
    logic [TW_W-1:0]   canvas_w;
    logic [TWS_W-1:0]  text_span;
    logic              scrolling;
    logic [SPD_W-1:0]  speed_code;
    logic [COLR_W-1:0] colour;
  } cfg_t;

  // scroll unit commands
  typedef struct packed {
    logic tick;
    logic restart;
  } scr_ctl_t;

  // byte handed to the blit unit
  typedef struct packed {
    logic              start;
    logic [ROW_W-1:0]  row;
    logic [BCOL_W-1:0] bcol;
    logic [PIX_W-1:0]  bits;
  } blt_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] q;
    logic [REM_W-1:0] r;
  } qr_t;

  typedef enum logic [2:0] {
    BLT_IDLE,
    BLT_BASE,
    BLT_ORIG,
    BLT_WALK,
    BLT_FLUSH
  } blt_state_t;

  typedef enum logic [1:0] {
    SCR_IDLE,
    SCR_STEP,
    SCR_WRAP
  } scr_state_t;

  // speed numerator per code, codes outside 1..10 mean 1/1
  function automatic logic [SPT_W-1:0] speed_num(input logic [SPD_W-1:0] code);
    logic [SPT_W-1:0] n;
    unique case (code)
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd3;
      4'd7:    n = 3'd5;
      4'd8:    n = 3'd3;
      4'd9:    n = 3'd7;
      4'd10:   n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [SPT_W-1:0] speed_den(input logic [SPD_W-1:0] code);
    logic [SPT_W-1:0] d;
    unique case (code)
      4'd1:    d = 3'd4;
      4'd2:    d = 3'd3;
      4'd3:    d = 3'd2;
      4'd4:    d = 3'd3;
      4'd5:    d = 3'd4;
      4'd7:    d = 3'd4;
      4'd8:    d = 3'd2;
      4'd9:    d = 3'd4;
      default: d = 3'd1;
    endcase
    return d;
  endfunction

  // quotient and remainder of a small accumulator by a denominator of 1..4
  function automatic qr_t div_small(input logic [ACC_W-1:0] acc,
                                    input logic [SPT_W-1:0] den);
    qr_t              res;
    logic [ACC_W-1:0] t;
    res = '0;
    t   = '0;
    unique case (den)
      3'd2: begin
        res.q = acc >> 1;
        res.r = {1'b0, acc[0]};
      end
      3'd3: begin
        if (acc >= 4'd9) begin
          res.q = 4'd3;
        end else if (acc >= 4'd6) begin
          res.q = 4'd2;
        end else if (acc >= 4'd3) begin
          res.q = 4'd1;
        end else begin
          res.q = 4'd0;
        end
        t     = acc - (res.q << 1) - res.q;
        res.r = t[REM_W-1:0];
      end
      3'd4: begin
        res.q = acc >> 2;
        res.r = acc[REM_W-1:0];
      end
      default: begin
        res.q = acc;
        res.r = '0;
      end
    endcase
    return res;
  endfunction

endpackage

>>> design/sbtb_in_if.sv
// ----------------------------------------------------------------------------
// sbtb_in_if
// command word channel into the blitter
// ----------------------------------------------------------------------------
interface sbtb_in_if;
  logic                         valid;
  logic                         ready;
  logic [sbtb_pkg::CMD_W-1:0]   cmd;
  logic [sbtb_pkg::ROW_W-1:0]   canvas_row;
  logic [sbtb_pkg::BCOL_W-1:0]  byte_column;
  logic [sbtb_pkg::PIX_W-1:0]   pixel_bits;

  modport source (output valid, cmd, canvas_row, byte_column, pixel_bits, input ready);
  modport sink   (input valid, cmd, canvas_row, byte_column, pixel_bits, output ready);
endinterface

>>> design/sbtb_out_if.sv
// ----------------------------------------------------------------------------
// sbtb_out_if
// square word channel out of the blitter
// ----------------------------------------------------------------------------
interface sbtb_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sbtb_pkg::SQX_W-1:0]  square_x;
  logic signed [sbtb_pkg::SQY_W-1:0]  square_y;
  logic [sbtb_pkg::SIDE_W-1:0]        square_side;
  logic [sbtb_pkg::COLR_W-1:0]        square_colour;
  logic                               last_square;

  modport source (output valid, square_x, square_y, square_side, square_colour, last_square,
                  input ready);
  modport sink   (input valid, square_x, square_y, square_side, square_colour, last_square,
                  output ready);
endinterface

>>> design/scrolling_bitmap_text_blitter.sv
// ----------------------------------------------------------------------------
// scrolling_bitmap_text_blitter
// maps a 1-bit text bitmap onto the panel as scaled squares, with scrolling
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake             | word
//  ---------+-----+-----------------------+-----------------------------------
//  in_bus   | in  | valid/ready           | cmd, canvas_row, byte_column, bits
//  out_bus  | out | valid/ready           | square x/y/side/colour, last mark
//  cfg_*    | in  | cfg_we, no back-press | cfg_index, cfg_wdata
//
//  a canvas byte goes from the accept cycle through the setup states base
//  and orig, then the bit walk shifts one pixel bit per cycle through the
//  shift register while the output does not stall, then the flush state;
//  a frame tick passes through the step state, and the wrap state while
//  the text scrolls; a restart acts at accept, an unknown command not at all
//  output stalls hold the bit walk when a second visible square is found
//  while the output register is still full, and hold the flush while the
//  last square of the byte waits for that register
//  synchronous active-low reset: scroll position to the right panel edge,
//  remainder to zero, registers to their reset values, no word pending
//
module scrolling_bitmap_text_blitter #(
  parameter int PANEL_WIDTH    = sbtb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT   = sbtb_pkg::DEF_PANEL_HEIGHT,
  parameter int MAX_TEXT_WIDTH = sbtb_pkg::DEF_MAX_TEXT_WIDTH,
  parameter int SCROLL_ROWS    = sbtb_pkg::DEF_SCROLL_ROWS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sbtb_in_if.sink                          in_bus,
  sbtb_out_if.source                       out_bus,
  input  logic                             cfg_we,
  input  logic [sbtb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbtb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  sbtb_pkg::cfg_t                      cfg;
  sbtb_pkg::scr_ctl_t                  scr_ctl;
  sbtb_pkg::blt_req_t                  blt_req;
  logic signed [sbtb_pkg::POS_W-1:0]   scroll_pos;
  logic                                scr_busy;
  logic                                blt_busy;
  logic                                in_ready;
  logic                                in_take;

  // register file plus clamped scale, text span and scroll decision
  sbtb_cfg #(
    .PANEL_WIDTH    (PANEL_WIDTH),
    .MAX_TEXT_WIDTH (MAX_TEXT_WIDTH)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // one word in flight at a time: either unit busy holds the input
  assign in_ready     = !blt_busy && !scr_busy;
  assign in_bus.ready = in_ready;
  assign in_take      = in_bus.valid && in_ready;

  // command decode, unknown codes fall through with no effect
  always_comb begin
    scr_ctl.tick    = in_take && (in_bus.cmd == sbtb_pkg::CMD_TICK);
    scr_ctl.restart = in_take && (in_bus.cmd == sbtb_pkg::CMD_RESTART);
    blt_req.start   = in_take && (in_bus.cmd == sbtb_pkg::CMD_BYTE);
    blt_req.row     = in_bus.canvas_row;
    blt_req.bcol    = in_bus.byte_column;
    blt_req.bits    = in_bus.pixel_bits;
  end

  // scroll position, advanced by the frame tick
  sbtb_scroll #(
    .PANEL_WIDTH (PANEL_WIDTH)
  ) u_scroll (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scr_ctl),
    .cfg   (cfg),
    .pos   (scroll_pos),
    .busy  (scr_busy)
  );

  // per-byte geometry and the bit walk, owns the output register
  sbtb_blit #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .SCROLL_ROWS  (SCROLL_ROWS)
  ) u_blit (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (blt_req),
    .cfg     (cfg),
    .pos     (scroll_pos),
    .busy    (blt_busy),
    .out_bus (out_bus)
  );

endmodule

>>> design/sbtb_cfg.sv
// ----------------------------------------------------------------------------
// sbtb_cfg
// configuration registers and the values derived from them
// ----------------------------------------------------------------------------
module sbtb_cfg #(
  parameter int PANEL_WIDTH    = sbtb_pkg::DEF_PANEL_WIDTH,
  parameter int MAX_TEXT_WIDTH = sbtb_pkg::DEF_MAX_TEXT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sbtb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbtb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output sbtb_pkg::cfg_t                   cfg
);

  localparam int TW_W   = sbtb_pkg::TW_W;
  localparam int TWS_W  = sbtb_pkg::TWS_W;
  localparam int SCL_W  = sbtb_pkg::SCL_W;
  localparam int CAP    = (MAX_TEXT_WIDTH < (1 << TW_W)) ? MAX_TEXT_WIDTH : (1 << TW_W) - 1;
  localparam logic [TW_W-1:0]  CAP_C = TW_W'(CAP);
  localparam logic [TWS_W:0]   PW_C  = (TWS_W + 1)'(PANEL_WIDTH);

  logic                             scroll_mode_r;
  logic [SCL_W-1:0]                 scale_r;
  logic [TW_W-1:0]                  text_width_r;
  logic [sbtb_pkg::SPD_W-1:0]       speed_code_r;
  logic [sbtb_pkg::COLR_W-1:0]      draw_colour_r;

  logic [SCL_W-1:0]                 s_eff;
  logic [TWS_W-1:0]                 span;
  logic [TW_W-1:0]                  w_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_mode_r <= 1'b0;
      scale_r       <= 3'd1;
      text_width_r  <= '0;
      speed_code_r  <= 4'd6;
      draw_colour_r <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbtb_pkg::CFG_SCROLL_MODE: scroll_mode_r <= cfg_wdata[0];
        sbtb_pkg::CFG_SCALE:       scale_r       <= cfg_wdata[SCL_W-1:0];
        sbtb_pkg::CFG_TEXT_WIDTH:  text_width_r  <= cfg_wdata[TW_W-1:0];
        sbtb_pkg::CFG_SPEED_CODE:  speed_code_r  <= cfg_wdata[sbtb_pkg::SPD_W-1:0];
        sbtb_pkg::CFG_DRAW_COLOUR: draw_colour_r <= cfg_wdata[sbtb_pkg::COLR_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp scale to 1..4
  always_comb begin
    if (scale_r == 3'd0) begin
      s_eff = 3'd1;
    end else if (scale_r > 3'd4) begin
      s_eff = 3'd4;
    end else begin
      s_eff = scale_r;
    end
  end

  assign span  = {{(TWS_W - TW_W){1'b0}}, text_width_r} * {{(TWS_W - SCL_W){1'b0}}, s_eff};
  assign w_raw = (text_width_r == '0) ? TW_W'(1) : text_width_r;

  always_comb begin
    cfg.scroll_mode = scroll_mode_r;
    cfg.scale_eff   = s_eff;
    cfg.canvas_w    = (w_raw > CAP_C) ? CAP_C : w_raw;
    cfg.text_span   = span;
    cfg.scrolling   = scroll_mode_r && ({1'b0, span} > PW_C);
    cfg.speed_code  = speed_code_r;
    cfg.colour      = draw_colour_r;
  end

endmodule

>>> design/sbtb_scroll.sv
// ----------------------------------------------------------------------------
// sbtb_scroll
// scroll position with fractional speed accumulator and wrap
// ----------------------------------------------------------------------------
module sbtb_scroll #(
  parameter int PANEL_WIDTH = sbtb_pkg::DEF_PANEL_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbtb_pkg::scr_ctl_t                  ctl,
  input  sbtb_pkg::cfg_t                      cfg,
  output logic signed [sbtb_pkg::POS_W-1:0]   pos,
  output logic                                busy
);

  localparam int POS_W = sbtb_pkg::POS_W;
  localparam int REM_W = sbtb_pkg::REM_W;
  localparam int ACC_W = sbtb_pkg::ACC_W;
  localparam logic signed [POS_W-1:0] HOME = POS_W'(PANEL_WIDTH);

  sbtb_pkg::scr_state_t        state_r, state_nxt;
  logic signed [POS_W-1:0]     pos_r, pos_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;

  logic [ACC_W-1:0]            acc;
  sbtb_pkg::qr_t               dv;
  logic signed [POS_W-1:0]     neg_span;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbtb_pkg::SCR_IDLE;
      pos_r   <= HOME;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_comb begin
    state_nxt = sbtb_pkg::SCR_IDLE;
    unique case (state_r)
      sbtb_pkg::SCR_IDLE: state_nxt = ctl.tick ? sbtb_pkg::SCR_STEP : sbtb_pkg::SCR_IDLE;
      sbtb_pkg::SCR_STEP: state_nxt = cfg.scrolling ? sbtb_pkg::SCR_WRAP : sbtb_pkg::SCR_IDLE;
      sbtb_pkg::SCR_WRAP: state_nxt = sbtb_pkg::SCR_IDLE;
      default:            state_nxt = sbtb_pkg::SCR_IDLE;
    endcase
  end

  // step: remainder plus numerator, split by denominator
  assign acc      = {{(ACC_W - REM_W){1'b0}}, rem_r}
                  + {{(ACC_W - sbtb_pkg::SPT_W){1'b0}}, sbtb_pkg::speed_num(cfg.speed_code)};
  assign dv       = sbtb_pkg::div_small(acc, sbtb_pkg::speed_den(cfg.speed_code));
  assign neg_span = -$signed({{(POS_W - sbtb_pkg::TWS_W){1'b0}}, cfg.text_span});

  always_comb begin
    pos_nxt = pos_r;
    rem_nxt = rem_r;
    unique case (state_r)
      sbtb_pkg::SCR_IDLE: begin
        if (ctl.restart) begin
          pos_nxt = HOME;
          rem_nxt = '0;
        end
      end
      sbtb_pkg::SCR_STEP: begin
        if (cfg.scrolling) begin
          pos_nxt = pos_r - $signed({{(POS_W - ACC_W){1'b0}}, dv.q});
          rem_nxt = dv.r;
        end
      end
      sbtb_pkg::SCR_WRAP: begin
        // text fully gone past the left edge
        if (pos_r < neg_span) begin
          pos_nxt = HOME;
          rem_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    busy = (state_r != sbtb_pkg::SCR_IDLE);
    pos  = pos_r;
  end

endmodule

>>> design/sbtb_blit.sv
// ----------------------------------------------------------------------------
// sbtb_blit
// bit-serial walk over one canvas byte, emitting visible squares
// ----------------------------------------------------------------------------
module sbtb_blit #(
  parameter int PANEL_WIDTH  = sbtb_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = sbtb_pkg::DEF_PANEL_HEIGHT,
  parameter int SCROLL_ROWS  = sbtb_pkg::DEF_SCROLL_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sbtb_pkg::blt_req_t                 req,
  input  sbtb_pkg::cfg_t                     cfg,
  input  logic signed [sbtb_pkg::POS_W-1:0]  pos,
  output logic                               busy,
  sbtb_out_if.source                         out_bus
);

  localparam int XW     = sbtb_pkg::X_W;
  localparam int YW     = sbtb_pkg::Y_W;
  localparam int CC_W   = sbtb_pkg::CC_W;
  localparam int ROW_W  = sbtb_pkg::ROW_W;
  localparam int BCOL_W = sbtb_pkg::BCOL_W;
  localparam int PIX_W  = sbtb_pkg::PIX_W;
  localparam int SCL_W  = sbtb_pkg::SCL_W;
  localparam int HGT_W  = sbtb_pkg::HGT_W;
  localparam int POS_W  = sbtb_pkg::POS_W;
  localparam int SQX_W  = sbtb_pkg::SQX_W;
  localparam int SQY_W  = sbtb_pkg::SQY_W;
  localparam int BI_W   = $clog2(PIX_W);
  localparam int RS_W   = ROW_W + SCL_W;

  localparam logic signed [XW-1:0] PW_X = XW'(PANEL_WIDTH);

  // per-scale canvas height and vertical offset
  localparam int HGT_ST  [4] = '{PANEL_HEIGHT / 1, PANEL_HEIGHT / 2,
                                 PANEL_HEIGHT / 3, PANEL_HEIGHT / 4};
  localparam int YOFF_ST [4] = '{(PANEL_HEIGHT - (PANEL_HEIGHT / 1) * 1) / 2,
                                 (PANEL_HEIGHT - (PANEL_HEIGHT / 2) * 2) / 2,
                                 (PANEL_HEIGHT - (PANEL_HEIGHT / 3) * 3) / 2,
                                 (PANEL_HEIGHT - (PANEL_HEIGHT / 4) * 4) / 2};
  localparam int YOFF_SC [4] = '{(PANEL_HEIGHT - SCROLL_ROWS * 1) / 2,
                                 (PANEL_HEIGHT - SCROLL_ROWS * 2) / 2,
                                 (PANEL_HEIGHT - SCROLL_ROWS * 3) / 2,
                                 (PANEL_HEIGHT - SCROLL_ROWS * 4) / 2};

  sbtb_pkg::blt_state_t        state_r, state_nxt;
  logic [ROW_W-1:0]            row_r, row_nxt;
  logic [BCOL_W-1:0]           bcol_r, bcol_nxt;
  logic [PIX_W-1:0]            sh_r, sh_nxt;
  logic signed [XW-1:0]        xbase_r, xbase_nxt;
  logic [CC_W-1:0]             bcs_r, bcs_nxt;
  logic signed [XW-1:0]        x_r, x_nxt;
  logic [CC_W-1:0]             col_r, col_nxt;
  logic signed [YW-1:0]        y_r, y_nxt;
  logic                        row_ok_r, row_ok_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic [SQX_W-1:0]            pend_x_r, pend_x_nxt;

  logic                        out_v_r, out_v_nxt;
  logic [SQX_W-1:0]            out_x_r, out_x_nxt;
  logic [SQY_W-1:0]            out_y_r, out_y_nxt;
  logic [SCL_W-1:0]            out_side_r, out_side_nxt;
  logic [sbtb_pkg::COLR_W-1:0] out_colour_r, out_colour_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [1:0]                  sidx;
  logic signed [XW-1:0]        s_x;
  logic signed [XW-1:0]        xs;
  logic signed [XW-1:0]        ctr_diff;
  logic signed [XW-1:0]        xbase_sel;
  logic [HGT_W-1:0]            h_sel;
  logic signed [YW-1:0]        yoff_sel;
  logic [RS_W-1:0]             rs;
  logic                        hi_ok, lo_ok, col_ok, qual;
  logic                        out_free, walk_adv, out_load, load_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sbtb_pkg::BLT_IDLE;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    bcol_r       <= bcol_nxt;
    sh_r         <= sh_nxt;
    xbase_r      <= xbase_nxt;
    bcs_r        <= bcs_nxt;
    x_r          <= x_nxt;
    col_r        <= col_nxt;
    y_r          <= y_nxt;
    row_ok_r     <= row_ok_nxt;
    pend_x_r     <= pend_x_nxt;
    out_x_r      <= out_x_nxt;
    out_y_r      <= out_y_nxt;
    out_side_r   <= out_side_nxt;
    out_colour_r <= out_colour_nxt;
    out_last_r   <= out_last_nxt;
  end

  // geometry helpers
  assign sidx      = 2'(cfg.scale_eff - 3'd1);
  assign s_x       = $signed({{(XW - SCL_W){1'b0}}, cfg.scale_eff});
  assign xs        = x_r + s_x;
  assign ctr_diff  = PW_X - $signed({{(XW - sbtb_pkg::TWS_W){1'b0}}, cfg.text_span});
  assign h_sel     = cfg.scroll_mode ? HGT_W'(SCROLL_ROWS) : HGT_W'(HGT_ST[sidx]);
  assign yoff_sel  = cfg.scroll_mode ? YW'(YOFF_SC[sidx]) : YW'(YOFF_ST[sidx]);
  assign rs        = {{SCL_W{1'b0}}, row_r} * {{ROW_W{1'b0}}, cfg.scale_eff};

  always_comb begin
    if (!cfg.scroll_mode) begin
      xbase_sel = '0;
    end else if (cfg.scrolling) begin
      xbase_sel = {{(XW - POS_W){pos[POS_W-1]}}, pos};
    end else begin
      xbase_sel = ctr_diff >>> 1;
    end
  end

  // visibility of the bit at the head of the shift register
  assign hi_ok  = !cfg.scroll_mode ? (xs <= PW_X) : (cfg.scrolling ? (x_r < PW_X) : 1'b1);
  assign lo_ok  = cfg.scrolling ? (xs > $signed(XW'(0))) : 1'b1;
  assign col_ok = !cfg.scroll_mode || (col_r < cfg.canvas_w);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbtb_pkg::BLT_IDLE:  state_nxt = req.start ? sbtb_pkg::BLT_BASE : sbtb_pkg::BLT_IDLE;
      sbtb_pkg::BLT_BASE:  state_nxt = sbtb_pkg::BLT_ORIG;
      sbtb_pkg::BLT_ORIG:  state_nxt = sbtb_pkg::BLT_WALK;
      sbtb_pkg::BLT_WALK: begin
        if (walk_adv && (col_r[BI_W-1:0] == BI_W'(PIX_W - 1))) begin
          state_nxt = sbtb_pkg::BLT_FLUSH;
        end
      end
      sbtb_pkg::BLT_FLUSH: begin
        if (!pend_v_r || out_free) begin
          state_nxt = sbtb_pkg::BLT_IDLE;
        end
      end
      default:             state_nxt = sbtb_pkg::BLT_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy      = (state_r != sbtb_pkg::BLT_IDLE);
    out_free  = !out_v_r || out_bus.ready;
    qual      = sh_r[PIX_W-1] && row_ok_r && hi_ok && lo_ok && col_ok;
    walk_adv  = 1'b0;
    out_load  = 1'b0;
    load_last = 1'b0;
    unique case (state_r)
      sbtb_pkg::BLT_WALK: begin
        // a second hit pushes the held one out, wait if the output is full
        walk_adv = !(qual && pend_v_r && !out_free);
        out_load = walk_adv && qual && pend_v_r;
      end
      sbtb_pkg::BLT_FLUSH: begin
        out_load  = pend_v_r && out_free;
        load_last = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    row_nxt        = row_r;
    bcol_nxt       = bcol_r;
    sh_nxt         = sh_r;
    xbase_nxt      = xbase_r;
    bcs_nxt        = bcs_r;
    x_nxt          = x_r;
    col_nxt        = col_r;
    y_nxt          = y_r;
    row_ok_nxt     = row_ok_r;
    pend_v_nxt     = pend_v_r;
    pend_x_nxt     = pend_x_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_side_nxt   = out_side_r;
    out_colour_nxt = out_colour_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      sbtb_pkg::BLT_IDLE: begin
        if (req.start) begin
          row_nxt  = req.row;
          bcol_nxt = req.bcol;
          sh_nxt   = req.bits;
        end
      end
      sbtb_pkg::BLT_BASE: begin
        xbase_nxt  = xbase_sel;
        bcs_nxt    = {{(CC_W - BCOL_W){1'b0}}, bcol_r} * {{(CC_W - SCL_W){1'b0}}, cfg.scale_eff};
        y_nxt      = yoff_sel + $signed({{(YW - RS_W){1'b0}}, rs});
        row_ok_nxt = {{(HGT_W - ROW_W){1'b0}}, row_r} < h_sel;
      end
      sbtb_pkg::BLT_ORIG: begin
        x_nxt      = xbase_r + $signed({{(XW - CC_W - BI_W){1'b0}}, bcs_r, {BI_W{1'b0}}});
        col_nxt    = CC_W'({bcol_r, {BI_W{1'b0}}});
        pend_v_nxt = 1'b0;
      end
      sbtb_pkg::BLT_WALK: begin
        if (walk_adv) begin
          x_nxt   = xs;
          col_nxt = col_r + CC_W'(1);
          sh_nxt  = sh_r << 1;
          if (qual) begin
            pend_x_nxt = x_r[SQX_W-1:0];
            pend_v_nxt = 1'b1;
          end
        end
      end
      sbtb_pkg::BLT_FLUSH: begin
        if (out_load) begin
          pend_v_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_v_nxt      = 1'b1;
      out_x_nxt      = pend_x_r;
      out_y_nxt      = y_r[SQY_W-1:0];
      out_side_nxt   = cfg.scale_eff;
      out_colour_nxt = cfg.colour;
      out_last_nxt   = load_last;
    end else begin
      out_v_nxt      = out_v_r && !out_bus.ready;
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.square_x      = out_x_r;
  assign out_bus.square_y      = out_y_r;
  assign out_bus.square_side   = out_side_r;
  assign out_bus.square_colour = out_colour_r;
  assign out_bus.last_square   = out_last_r;

endmodule

>>> design/sbtb_checker.sv
// ----------------------------------------------------------------------------
// sbtb_checker
// port-level checks on the blitter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbtb_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [sbtb_pkg::CMD_W-1:0]         in_cmd,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [sbtb_pkg::SQX_W-1:0]  out_x,
  input logic signed [sbtb_pkg::SQY_W-1:0]  out_y,
  input logic [sbtb_pkg::SIDE_W-1:0]        out_side,
  input logic [sbtb_pkg::COLR_W-1:0]        out_colour,
  input logic                               out_last
);

  logic in_take;
  logic out_stall;

  assign in_take   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // a stalled word holds
  `SBTB_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_side) && $stable(out_colour) && $stable(out_last))

  // a canvas byte keeps the input closed while it is walked
  `SBTB_ASSERT_NEXT(a_byte_busy, in_take && (in_cmd == sbtb_pkg::CMD_BYTE), !in_ready)

  // no square appears in the cycle right after an accept made while no square is valid
  `SBTB_ASSERT_NEXT(a_no_early_word, in_take && !out_valid, !out_valid)

  // side always lies in the clamped scale range 1..4
  `SBTB_ASSERT_NOW(a_side_range, out_valid, (out_side == 3'd1) || (out_side == 3'd2) || (out_side == 3'd3) || (out_side == 3'd4))

endmodule

bind scrolling_bitmap_text_blitter sbtb_checker u_sbtb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .in_cmd     (in_bus.cmd),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_x      (out_bus.square_x),
  .out_y      (out_bus.square_y),
  .out_side   (out_bus.square_side),
  .out_colour (out_bus.square_colour),
  .out_last   (out_bus.last_square)
);
